// ===== rtl/core/axrot_pkg.sv =====
// Shared types, codes and default constants for the axis rotation block.
package axrot_pkg;

  // Default geometry
  localparam int COORD_WIDTH_DEF = 24;
  localparam int TRIG_FRAC_DEF   = 14;
  localparam int TRIG_W          = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_W       = 3;

  // Cosine after reset: 1.0 in Q1.14
  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

  // Rotation axis codes
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS    = 3'd0,
    REG_COS     = 3'd1,
    REG_SIN     = 3'd2,
    REG_PIVOT_X = 3'd3,
    REG_PIVOT_Y = 3'd4,
    REG_PIVOT_Z = 3'd5
  } cfg_idx_t;

  // Width of one queue entry between front and back
  function automatic int entry_w(int cw);
    return 7 * cw + 5;
  endfunction

endpackage

// ===== rtl/core/axrot_if.sv =====
// Vertex input and result output channel interfaces.
interface axrot_in_if import axrot_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] coord_x;
  logic signed [CW-1:0] coord_y;
  logic signed [CW-1:0] coord_z;
  logic                 first;

  modport source (output valid, coord_x, coord_y, coord_z, first, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, first, output ready);
endinterface

interface axrot_out_if import axrot_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic signed [CW-1:0] box_min_x;
  logic signed [CW-1:0] box_min_y;
  logic signed [CW-1:0] box_min_z;
  logic signed [CW-1:0] box_max_x;
  logic signed [CW-1:0] box_max_y;
  logic signed [CW-1:0] box_max_z;

  modport source (output valid, out_x, out_y, out_z, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, output ready);
endinterface

// ===== rtl/core/axrot_front.sv =====
// Front end: accepts vertex words, picks the rotated pair and forms pivot offsets.
module axrot_front import axrot_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int EW = entry_w(CW)
) (
  axrot_in_if.sink       in_vtx,
  input  axis_t          axis,
  input  logic [CW-1:0]  pivot_x,
  input  logic [CW-1:0]  pivot_y,
  input  logic [CW-1:0]  pivot_z,
  output logic           push_valid,
  input  logic           push_ready,
  output logic [EW-1:0]  push_data
);

  typedef struct packed {
    axis_t          axis;
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic [CW-1:0]  z;
    logic [CW:0]    da;
    logic [CW:0]    db;
    logic [CW-1:0]  piv_a;
    logic [CW-1:0]  piv_b;
    logic           first;
  } entry_t;

  entry_t        ent;
  logic [CW-1:0] a;
  logic [CW-1:0] b;
  logic [CW-1:0] pa;
  logic [CW-1:0] pb;

  // Select the coordinate pair that the axis rotates
  always_comb begin
    case (axis)
      AXIS_X: begin
        a = in_vtx.coord_y; b = in_vtx.coord_z; pa = pivot_y; pb = pivot_z;
      end
      AXIS_Y: begin
        a = in_vtx.coord_x; b = in_vtx.coord_z; pa = pivot_x; pb = pivot_z;
      end
      default: begin
        a = in_vtx.coord_x; b = in_vtx.coord_y; pa = pivot_x; pb = pivot_y;
      end
    endcase
  end

  // Form pivot-relative offsets, one bit wider to hold any difference
  always_comb begin
    ent.axis  = axis;
    ent.x     = in_vtx.coord_x;
    ent.y     = in_vtx.coord_y;
    ent.z     = in_vtx.coord_z;
    ent.da    = {a[CW-1], a} - {pa[CW-1], pa};
    ent.db    = {b[CW-1], b} - {pb[CW-1], pb};
    ent.piv_a = pa;
    ent.piv_b = pb;
    ent.first = in_vtx.first;
  end

  // Push straight into the queue
  assign push_data    = ent;
  assign push_valid   = in_vtx.valid;
  assign in_vtx.ready = push_ready;

endmodule

// ===== rtl/core/axrot_fifo.sv =====
// Short register queue that decouples the front end from the arithmetic back end.
module axrot_fifo import axrot_pkg::*; #(
  parameter int W     = entry_w(COORD_WIDTH_DEF),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0]   FULL = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/axrot_back.sv =====
// Back end: multiply, round, add pivot back, saturate and track the bounding box.
module axrot_back import axrot_pkg::*; #(
  parameter int CW  = COORD_WIDTH_DEF,
  parameter int TFB = TRIG_FRAC_DEF,
  parameter int EW  = entry_w(CW)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  logic [EW-1:0]            pop_data,
  input  logic signed [TRIG_W-1:0] cos_theta,
  input  logic signed [TRIG_W-1:0] sin_theta,
  axrot_out_if.source              out_res
);

  localparam int PW = TRIG_W + CW + 1;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (TFB - 1);
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    axis_t          axis;
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic [CW-1:0]  z;
    logic [CW:0]    da;
    logic [CW:0]    db;
    logic [CW-1:0]  piv_a;
    logic [CW-1:0]  piv_b;
    logic           first;
  } entry_t;

  // Clamp a wide value to the coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic fits;
    fits = (v[SW-1:CW-1] == '0) || (v[SW-1:CW-1] == '1);
    if (fits) begin
      return v[CW-1:0];
    end
    return v[SW-1] ? C_MIN : C_MAX;
  endfunction

  entry_t ent;
  assign ent = entry_t'(pop_data);

  // Stage handshake
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_res.ready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign pop_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= pop_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: four products
  entry_t             e1_r;
  logic signed [PW-1:0] p_ca_r, p_sb_r, p_sa_r, p_cb_r;

  always_ff @(posedge clk) begin
    if (rdy1 && pop_valid) begin
      e1_r   <= ent;
      p_ca_r <= cos_theta * $signed(ent.da);
      p_sb_r <= sin_theta * $signed(ent.db);
      p_sa_r <= sin_theta * $signed(ent.da);
      p_cb_r <= cos_theta * $signed(ent.db);
    end
  end

  // Stage 2: exact sums with the rounding half added
  entry_t               e2_r;
  logic signed [SW-1:0] sum_a_r, sum_b_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      e2_r    <= e1_r;
      sum_a_r <= SW'(p_ca_r) - SW'(p_sb_r) + HALF;
      sum_b_r <= SW'(p_sa_r) + SW'(p_cb_r) + HALF;
    end
  end

  // Stage 3: drop fraction, add pivot back, saturate, place into the vertex
  logic signed [SW-1:0] na_w, nb_w;
  logic [CW-1:0]        na, nb;
  logic [CW-1:0]        x3_nxt, y3_nxt, z3_nxt;
  logic [CW-1:0]        x3_r, y3_r, z3_r;
  logic                 first3_r;

  always_comb begin
    na_w = (sum_a_r >>> TFB) + $signed({{(SW-CW){e2_r.piv_a[CW-1]}}, e2_r.piv_a});
    nb_w = (sum_b_r >>> TFB) + $signed({{(SW-CW){e2_r.piv_b[CW-1]}}, e2_r.piv_b});
    na   = sat_coord(na_w);
    nb   = sat_coord(nb_w);
    x3_nxt = e2_r.x;
    y3_nxt = e2_r.y;
    z3_nxt = e2_r.z;
    case (e2_r.axis)
      AXIS_X: begin
        y3_nxt = na; z3_nxt = nb;
      end
      AXIS_Y: begin
        x3_nxt = na; z3_nxt = nb;
      end
      AXIS_Z: begin
        x3_nxt = na; y3_nxt = nb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      x3_r     <= x3_nxt;
      y3_r     <= y3_nxt;
      z3_r     <= z3_nxt;
      first3_r <= e2_r.first;
    end
  end

  // Stage 4: output word and running box
  logic signed [CW-1:0] ox_r, oy_r, oz_r;
  logic signed [CW-1:0] min_x_r, min_y_r, min_z_r, max_x_r, max_y_r, max_z_r;
  logic signed [CW-1:0] min_x_nxt, min_y_nxt, min_z_nxt;
  logic signed [CW-1:0] max_x_nxt, max_y_nxt, max_z_nxt;
  logic signed [CW-1:0] sx, sy, sz;

  assign sx = x3_r;
  assign sy = y3_r;
  assign sz = z3_r;

  // Restart the box on a first word, otherwise widen it
  always_comb begin
    if (first3_r) begin
      min_x_nxt = sx; min_y_nxt = sy; min_z_nxt = sz;
      max_x_nxt = sx; max_y_nxt = sy; max_z_nxt = sz;
    end else begin
      min_x_nxt = (sx < min_x_r) ? sx : min_x_r;
      min_y_nxt = (sy < min_y_r) ? sy : min_y_r;
      min_z_nxt = (sz < min_z_r) ? sz : min_z_r;
      max_x_nxt = (sx > max_x_r) ? sx : max_x_r;
      max_y_nxt = (sy > max_y_r) ? sy : max_y_r;
      max_z_nxt = (sz > max_z_r) ? sz : max_z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0;
      min_y_r <= '0;
      min_z_r <= '0;
      max_x_r <= '0;
      max_y_r <= '0;
      max_z_r <= '0;
    end else if (rdy4 && v3_r) begin
      min_x_r <= min_x_nxt;
      min_y_r <= min_y_nxt;
      min_z_r <= min_z_nxt;
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
      max_z_r <= max_z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      ox_r <= sx;
      oy_r <= sy;
      oz_r <= sz;
    end
  end

  // Drive the result channel; the box registers hold this word's box
  assign out_res.valid     = v4_r;
  assign out_res.out_x     = ox_r;
  assign out_res.out_y     = oy_r;
  assign out_res.out_z     = oz_r;
  assign out_res.box_min_x = min_x_r;
  assign out_res.box_min_y = min_y_r;
  assign out_res.box_min_z = min_z_r;
  assign out_res.box_max_x = max_x_r;
  assign out_res.box_max_y = max_y_r;
  assign out_res.box_max_z = max_z_r;

endmodule

// ===== rtl/core/axis_rotation_with_bbox.sv =====
// Top level: configuration registers, front end, queue and arithmetic back end.
//
//  port group  dir   handshake          payload
//  in_vtx      in    valid / ready      coord_x, coord_y, coord_z, first
//  out_res     out   valid / ready      out_x/y/z, box_min_x/y/z, box_max_x/y/z
//  cfg_*       in    cfg_we, no wait    cfg_idx, cfg_data
//
// One vertex word per clock sustained while out_res.ready holds high; a result word passes
// through the queue entry (written at the accepting edge), then through four
// back-end stages: products, sums, round/pivot/saturate, box update and output register.
// Reset is synchronous: config returns to axis x, cos 1.0, sin 0, pivots 0, box 0.
// A stalled result holds the back end; the two-word queue then fills and in_vtx.ready
// drops, so the input side stalls without losing words.
module axis_rotation_with_bbox import axrot_pkg::*; #(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  axrot_in_if.sink               in_vtx,
  axrot_out_if.source            out_res,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int EW = entry_w(COORD_WIDTH);

  axis_t                   axis_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic [COORD_WIDTH-1:0]  pivot_x_r, pivot_y_r, pivot_z_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r    <= AXIS_X;
      cos_r     <= COS_RESET;
      sin_r     <= '0;
      pivot_x_r <= '0;
      pivot_y_r <= '0;
      pivot_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_AXIS:    axis_r    <= axis_t'(cfg_data[1:0]);
        REG_COS:     cos_r     <= cfg_data[TRIG_W-1:0];
        REG_SIN:     sin_r     <= cfg_data[TRIG_W-1:0];
        REG_PIVOT_X: pivot_x_r <= cfg_data;
        REG_PIVOT_Y: pivot_y_r <= cfg_data;
        REG_PIVOT_Z: pivot_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic          push_valid, push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [EW-1:0] pop_data;

  axrot_front #(
    .CW (COORD_WIDTH),
    .EW (EW)
  ) u_front (
    .in_vtx     (in_vtx),
    .axis       (axis_r),
    .pivot_x    (pivot_x_r),
    .pivot_y    (pivot_y_r),
    .pivot_z    (pivot_z_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  axrot_fifo #(
    .W     (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  axrot_back #(
    .CW  (COORD_WIDTH),
    .TFB (TRIG_FRAC_BITS),
    .EW  (EW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cos_theta (cos_r),
    .sin_theta (sin_r),
    .out_res   (out_res)
  );

endmodule
